>>> rtl/b2h_pkg.sv
// ----------------------------------------------------------------------------
// b2h_pkg
// Shared types and widths for the pixel color space converter.
// ----------------------------------------------------------------------------
package b2h_pkg;

  localparam int unsigned PIX_W  = 8;   // width of one color channel
  localparam int unsigned HNUM_W = 18;  // hue dividend, 2*H + d < 2^18
  localparam int unsigned HDEN_W = 10;  // hue divisor, 4*d
  localparam int unsigned SNUM_W = 17;  // saturation dividend, 510*d + max
  localparam int unsigned SDEN_W = 9;   // saturation divisor, 2*max
  localparam int unsigned HACC_W = 17;  // hue in degrees times d, H < 360*d

  // Channel that supplies the hue sector.
  typedef enum logic [1:0] {
    SEC_RED,
    SEC_GREEN,
    SEC_BLUE
  } sector_e;

  // One converted pixel.
  typedef struct packed {
    logic [PIX_W-1:0] brightness;
    logic [PIX_W-1:0] saturation;
    logic [PIX_W-1:0] hue;
  } hsv_t;

endpackage

>>> rtl/b2h_div.sv
// ----------------------------------------------------------------------------
// b2h_div
// Pipelined restoring divider, one quotient bit per register stage.
// ----------------------------------------------------------------------------
module b2h_div #(
  parameter int unsigned NUM_W = 18,
  parameter int unsigned DEN_W = 10,
  parameter int unsigned QUO_W = 8
) (
  input  logic             clk_i,
  input  logic             en_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  output logic [QUO_W-1:0] quo_o
);

  localparam int unsigned CMP_W = (NUM_W > DEN_W + QUO_W) ? NUM_W : DEN_W + QUO_W;

  logic [NUM_W-1:0] rem_q [QUO_W];
  logic [DEN_W-1:0] den_q [QUO_W];
  logic [QUO_W-1:0] quo_q [QUO_W];

  for (genvar k = 0; k < QUO_W; k++) begin : g_stage
    localparam int unsigned BIT = QUO_W - 1 - k;

    logic [NUM_W-1:0] rem_in;
    logic [DEN_W-1:0] den_in;
    logic [QUO_W-1:0] quo_in;
    logic [CMP_W-1:0] trial;
    logic [CMP_W-1:0] rem_ext;
    logic             fits;
    logic [NUM_W-1:0] rem_d;
    logic [QUO_W-1:0] quo_d;

    if (k == 0) begin : g_first
      assign rem_in = num_i;
      assign den_in = den_i;
      assign quo_in = '0;
    end else begin : g_next
      assign rem_in = rem_q[k-1];
      assign den_in = den_q[k-1];
      assign quo_in = quo_q[k-1];
    end

    always_comb begin
      trial   = CMP_W'(den_in) << BIT;
      rem_ext = CMP_W'(rem_in);
      fits    = (rem_ext >= trial);
      rem_d   = fits ? NUM_W'(rem_ext - trial) : rem_in;
      quo_d   = quo_in | (QUO_W'(fits) << BIT);
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k] <= rem_d;
        den_q[k] <= den_in;
        quo_q[k] <= quo_d;
      end
    end
  end

  assign quo_o = quo_q[QUO_W-1];

endmodule

>>> rtl/bgr_to_hsv_8bit.sv
// ----------------------------------------------------------------------------
// bgr_to_hsv_8bit
// Streaming converter from 8-bit blue, green, red pixels to 8-bit HSV.
// ----------------------------------------------------------------------------
// The block takes one pixel per clock while the skid register is empty and
// returns one HSV pixel per input pixel, in order. An accepted beat passes
// stage A, stage B, the dividers and the output register. Throughput is one
// beat per cycle while the skid register is empty: two arithmetic stages
// find the maximum, the minimum, the hue sector and the two dividends, and
// then two pipelined restoring dividers produce one quotient bit per stage
// over eight stages. Hue comes out in two-degree steps (0..180), saturation
// in 0..255 and brightness is the largest channel. Grey pixels give hue
// zero and black pixels give saturation zero. A skid register at the output
// lets the pipeline keep moving while a result waits, so input ready never
// depends on output ready in the same cycle. No state is kept between pixels.
// ----------------------------------------------------------------------------
module bgr_to_hsv_8bit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // blue [7:0], green [15:8], red [23:16]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata    // hue [7:0], saturation [15:8],
                                      // brightness [23:16]
);

  import b2h_pkg::*;

  // Stage A and stage B, then one stage per quotient bit.
  localparam int unsigned NSTG = 2 + PIX_W;

  // The whole pipeline moves together; it only freezes when the skid
  // register is holding a beat.
  logic en;

  logic [NSTG-1:0] valid_q;

  // ---------------- Stage A: max, min, sector and channel difference ------
  logic [PIX_W-1:0] blue, green, red;
  logic [PIX_W-1:0] max_d, min_d;
  sector_e          sec_d;
  logic signed [PIX_W:0] diff_d;

  logic [PIX_W-1:0]      a_max_q;
  logic [PIX_W-1:0]      a_dlt_q;
  sector_e               a_sec_q;
  logic signed [PIX_W:0] a_diff_q;

  assign blue  = s_axis_tdata[7:0];
  assign green = s_axis_tdata[15:8];
  assign red   = s_axis_tdata[23:16];

  always_comb begin
    max_d = (red > green) ? red : green;
    max_d = (max_d > blue) ? max_d : blue;
    min_d = (red < green) ? red : green;
    min_d = (min_d < blue) ? min_d : blue;
    // Ties go to red first, then green.
    if (red == max_d) begin
      sec_d  = SEC_RED;
      diff_d = $signed({1'b0, green}) - $signed({1'b0, blue});
    end else if (green == max_d) begin
      sec_d  = SEC_GREEN;
      diff_d = $signed({1'b0, blue}) - $signed({1'b0, red});
    end else begin
      sec_d  = SEC_BLUE;
      diff_d = $signed({1'b0, red}) - $signed({1'b0, green});
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      a_max_q  <= max_d;
      a_dlt_q  <= max_d - min_d;
      a_sec_q  <= sec_d;
      a_diff_q <= diff_d;
    end
  end

  // ---------------- Stage B: dividends and divisors -----------------------
  // H is the hue in degrees times d: 60*diff plus a sector offset. For the
  // red sector the offset of 360*d applies only when the difference is
  // negative, which keeps H below 360*d.
  logic signed [15:0]     prod60;
  logic [HACC_W-1:0]      dlt_x;
  logic [HACC_W-1:0]      offs;
  logic signed [HACC_W+1:0] hacc;
  logic [HACC_W-1:0]      hdeg;
  logic [HNUM_W-1:0]      hnum_d;
  logic [HDEN_W-1:0]      hden_d;
  logic [SNUM_W-1:0]      snum_d;
  logic [SDEN_W-1:0]      sden_d;

  logic [HNUM_W-1:0] b_hnum_q;
  logic [HDEN_W-1:0] b_hden_q;
  logic [SNUM_W-1:0] b_snum_q;
  logic [SDEN_W-1:0] b_sden_q;
  logic [PIX_W-1:0]  b_max_q;

  always_comb begin
    prod60 = 16'(a_diff_q) * 16'sd60;
    dlt_x  = HACC_W'(a_dlt_q);
    case (a_sec_q)
      SEC_RED:   offs = a_diff_q[PIX_W] ? HACC_W'(dlt_x * HACC_W'(360)) : '0;
      SEC_GREEN: offs = HACC_W'(dlt_x * HACC_W'(120));
      SEC_BLUE:  offs = HACC_W'(dlt_x * HACC_W'(240));
      default:   offs = '0;
    endcase
    hacc = (HACC_W+2)'(prod60) + $signed({2'b00, offs});
    hdeg = hacc[HACC_W-1:0];
    // A grey pixel divides zero by one, giving hue zero.
    if (a_dlt_q == '0) begin
      hnum_d = '0;
      hden_d = HDEN_W'(1);
    end else begin
      hnum_d = {hdeg, 1'b0} + HNUM_W'(a_dlt_q);
      hden_d = {a_dlt_q, 2'b00};
    end
    // Rounding half up: (510*d + max) / (2*max).
    snum_d = SNUM_W'(SNUM_W'(a_dlt_q) * SNUM_W'(510)) + SNUM_W'(a_max_q);
    sden_d = (a_max_q == '0) ? SDEN_W'(1) : {a_max_q, 1'b0};
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      b_hnum_q <= hnum_d;
      b_hden_q <= hden_d;
      b_snum_q <= snum_d;
      b_sden_q <= sden_d;
      b_max_q  <= a_max_q;
    end
  end

  // ---------------- Division stages ---------------------------------------
  logic [PIX_W-1:0] hue_quo;
  logic [PIX_W-1:0] sat_quo;
  logic [PIX_W-1:0] bright_q [PIX_W];

  b2h_div #(
    .NUM_W (HNUM_W),
    .DEN_W (HDEN_W),
    .QUO_W (PIX_W)
  ) u_hue_div (
    .clk_i (clk_i),
    .en_i  (en),
    .num_i (b_hnum_q),
    .den_i (b_hden_q),
    .quo_o (hue_quo)
  );

  b2h_div #(
    .NUM_W (SNUM_W),
    .DEN_W (SDEN_W),
    .QUO_W (PIX_W)
  ) u_sat_div (
    .clk_i (clk_i),
    .en_i  (en),
    .num_i (b_snum_q),
    .den_i (b_sden_q),
    .quo_o (sat_quo)
  );

  // Brightness rides along beside the dividers.
  always_ff @(posedge clk_i) begin
    if (en) begin
      bright_q[0] <= b_max_q;
      for (int i = 1; i < PIX_W; i++) begin
        bright_q[i] <= bright_q[i-1];
      end
    end
  end

  // Valid bits travel with the data through every stage.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (en) begin
      valid_q <= {valid_q[NSTG-2:0], s_axis_tvalid};
    end
  end

  // ---------------- Output register and skid register ---------------------
  hsv_t last_pix;
  hsv_t out_q, skid_q;
  logic out_valid_q, skid_valid_q;
  logic m_take;
  logic last_valid;

  assign last_pix.hue        = hue_quo;
  assign last_pix.saturation = sat_quo;
  assign last_pix.brightness = bright_q[PIX_W-1];
  assign last_valid          = valid_q[NSTG-1];

  assign en            = ~skid_valid_q;
  assign s_axis_tready = en;
  assign m_take        = out_valid_q & m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      // Pipeline is frozen; the skid beat moves up once the output drains.
      if (m_take) begin
        skid_valid_q <= 1'b0;
      end
    end else if (last_valid) begin
      if (out_valid_q && !m_take) begin
        skid_valid_q <= 1'b1;
      end else begin
        out_valid_q <= 1'b1;
      end
    end else if (m_take) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (m_take) begin
        out_q <= skid_q;
      end
    end else if (last_valid) begin
      if (out_valid_q && !m_take) begin
        skid_q <= last_pix;
      end else begin
        out_q <= last_pix;
      end
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_q;

endmodule
